### src/rwl_pkg.sv
package rwl_pkg;

    // Operation codes carried in the func field of a request.
    typedef enum logic [2:0] {
        FN_TRY_READ      = 3'd0,
        FN_TRY_WRITE     = 3'd1,
        FN_ANNOUNCE      = 3'd2,
        FN_ANNOUNCED_TRY = 3'd3,
        FN_READ_UNLOCK   = 3'd4,
        FN_WRITE_UNLOCK  = 3'd5,
        FN_STATS_READ    = 3'd6,
        FN_STATS_CLEAR   = 3'd7
    } func_t;

    localparam int CPU_W     = 3;
    localparam int READERS_W = 8;
    localparam int WAITING_W = 4;
    localparam int COUNT_W   = 32;

    // Largest counts that fit the fixed field widths.
    localparam int READERS_CAP = 255;
    localparam int WAITING_CAP = 15;

    // Number of CPU indexes that the cpu field can name.
    localparam int CPU_CODES = 8;

    // Counter bank control, driven by the lock core.
    typedef struct packed {
        logic             known;
        logic             rd_inc;
        logic             wr_inc;
        logic             clear;
        logic [CPU_W-1:0] idx;
    } cnt_ctl_t;

    // One response as computed by the lock core.
    typedef struct packed {
        logic                 granted;
        logic                 fault;
        logic [READERS_W-1:0] readers_now;
        logic                 writer_held;
        logic [WAITING_W-1:0] writers_waiting;
        logic [COUNT_W-1:0]   read_grants_seen;
        logic [COUNT_W-1:0]   write_grants_seen;
    } rsp_t;

endpackage

### src/rwl_req_if.sv
interface rwl_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [2:0] cpu;

    modport source (output valid, output func, output cpu, input ready);
    modport sink (input valid, input func, input cpu, output ready);
endinterface

### src/rwl_rsp_if.sv
interface rwl_rsp_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic        fault;
    logic [7:0]  readers_now;
    logic        writer_held;
    logic [3:0]  writers_waiting;
    logic [31:0] read_grants_seen;
    logic [31:0] write_grants_seen;

    modport source (
        output valid, output granted, output fault, output readers_now,
        output writer_held, output writers_waiting, output read_grants_seen,
        output write_grants_seen, input ready
    );
    modport sink (
        input valid, input granted, input fault, input readers_now,
        input writer_held, input writers_waiting, input read_grants_seen,
        input write_grants_seen, output ready
    );
endinterface

### src/rwl_counters.sv
module rwl_counters #(
    parameter int CPU_COUNT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  rwl_pkg::cnt_ctl_t ctl,
    output logic [31:0]       rd_count,
    output logic [31:0]       wr_count
);
    import rwl_pkg::*;

    localparam int DEPTH = (CPU_COUNT < CPU_CODES) ? CPU_COUNT : CPU_CODES;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [COUNT_W-1:0] rd_cnt_reg [DEPTH];
    logic [COUNT_W-1:0] wr_cnt_reg [DEPTH];
    logic [IDX_W-1:0]   idx;

    assign idx = ctl.idx[IDX_W-1:0];

    // Counts are zero for a CPU index that has no counter.
    assign rd_count = ctl.known ? rd_cnt_reg[idx] : '0;
    assign wr_count = ctl.known ? wr_cnt_reg[idx] : '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_lane
        logic hit;
        assign hit = fire && ctl.known && (ctl.idx == CPU_W'(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rd_cnt_reg[i] <= '0;
                wr_cnt_reg[i] <= '0;
            end
            else if (fire && ctl.clear)
            begin
                rd_cnt_reg[i] <= '0;
                wr_cnt_reg[i] <= '0;
            end
            else
            begin
                if (hit && ctl.rd_inc)
                begin
                    rd_cnt_reg[i] <= rd_cnt_reg[i] + COUNT_W'(1);
                end
                if (hit && ctl.wr_inc)
                begin
                    wr_cnt_reg[i] <= wr_cnt_reg[i] + COUNT_W'(1);
                end
            end
        end
    end
endmodule

### src/rwl_core.sv
module rwl_core #(
    parameter int CPU_COUNT  = 8,
    parameter int READER_MAX = 255
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [2:0]        func,
    input  logic [2:0]        cpu,
    input  logic [31:0]       rd_count,
    input  logic [31:0]       wr_count,
    output rwl_pkg::cnt_ctl_t ctl,
    output rwl_pkg::rsp_t     rsp
);
    import rwl_pkg::*;

    localparam int READ_LIMIT = (READER_MAX < READERS_CAP) ? READER_MAX : READERS_CAP;
    localparam int WAIT_LIMIT = (CPU_COUNT < WAITING_CAP) ? CPU_COUNT : WAITING_CAP;

    logic [READERS_W-1:0] readers_reg, readers_next;
    logic                 wflag_reg, wflag_next;
    logic [CPU_W-1:0]     owner_reg, owner_next;
    logic [WAITING_W-1:0] waiting_reg, waiting_next;
    logic                 known;
    logic                 write_free;
    logic                 granted;
    logic                 fault;

    assign known      = 7'(cpu) < 7'(CPU_COUNT);
    assign write_free = !wflag_reg && (readers_reg == '0);

    always_comb
    begin
        readers_next = readers_reg;
        wflag_next   = wflag_reg;
        owner_next   = owner_reg;
        waiting_next = waiting_reg;
        granted      = 1'b0;
        fault        = 1'b0;
        ctl          = '0;
        ctl.known    = known;
        ctl.idx      = cpu;
        unique case (func_t'(func))
            FN_TRY_READ:
            begin
                if (!wflag_reg && waiting_reg == '0 && readers_reg < READERS_W'(READ_LIMIT))
                begin
                    readers_next = readers_reg + READERS_W'(1);
                    granted      = 1'b1;
                    ctl.rd_inc   = 1'b1;
                end
            end
            FN_TRY_WRITE:
            begin
                if (write_free)
                begin
                    wflag_next = 1'b1;
                    owner_next = cpu;
                    granted    = 1'b1;
                    ctl.wr_inc = 1'b1;
                end
            end
            FN_ANNOUNCE:
            begin
                if (waiting_reg >= WAITING_W'(WAIT_LIMIT))
                begin
                    fault = 1'b1;
                end
                else
                begin
                    waiting_next = waiting_reg + WAITING_W'(1);
                end
            end
            FN_ANNOUNCED_TRY:
            begin
                if (write_free)
                begin
                    wflag_next = 1'b1;
                    owner_next = cpu;
                    granted    = 1'b1;
                    ctl.wr_inc = 1'b1;
                    if (waiting_reg != '0)
                    begin
                        waiting_next = waiting_reg - WAITING_W'(1);
                    end
                end
            end
            FN_READ_UNLOCK:
            begin
                if (readers_reg == '0)
                begin
                    fault = 1'b1;
                end
                else
                begin
                    readers_next = readers_reg - READERS_W'(1);
                end
            end
            FN_WRITE_UNLOCK:
            begin
                if (!wflag_reg || owner_reg != cpu)
                begin
                    fault = 1'b1;
                end
                else
                begin
                    wflag_next = 1'b0;
                    owner_next = '0;
                end
            end
            FN_STATS_READ:
            begin
            end
            FN_STATS_CLEAR:
            begin
                ctl.clear = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp                   = '0;
        rsp.granted           = granted;
        rsp.fault             = fault;
        rsp.readers_now       = readers_next;
        rsp.writer_held       = wflag_next;
        rsp.writers_waiting   = waiting_next;
        if (func_t'(func) == FN_STATS_READ)
        begin
            rsp.read_grants_seen  = rd_count;
            rsp.write_grants_seen = wr_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            readers_reg <= '0;
            wflag_reg   <= 1'b0;
            owner_reg   <= '0;
            waiting_reg <= '0;
        end
        else if (fire)
        begin
            readers_reg <= readers_next;
            wflag_reg   <= wflag_next;
            owner_reg   <= owner_next;
            waiting_reg <= waiting_next;
        end
    end
endmodule

### src/reader_writer_lock_unit.sv
// Reader-writer lock unit, writer preferring.
// A request accepted into the input register is worked on by the core, and its
// response goes into the response register once that register can take it.
// One request per cycle while responses are taken; the update is a single pass.
// Reset (rst_n, asynchronous): lock state, waiting count, all grant counters
// and both pipeline valid flags clear at once; no request is refused after it.
module reader_writer_lock_unit #(
    parameter int CPU_COUNT  = 8,
    parameter int READER_MAX = 255
) (
    input  logic         clk,
    input  logic         rst_n,
    rwl_req_if.sink      req,
    rwl_rsp_if.source    rsp
);
    import rwl_pkg::*;

    // Input register holding one accepted request.
    logic       req_valid_reg;
    logic [2:0] func_reg;
    logic [2:0] cpu_reg;

    // Response register.
    logic       rsp_valid_reg;
    rsp_t       rsp_reg;

    logic       advance;
    logic       req_take;
    cnt_ctl_t   cnt_ctl;
    rsp_t       rsp_calc;
    logic [31:0] rd_count;
    logic [31:0] wr_count;

    // The held request moves on whenever the response register is empty or
    // its current response is being taken. Lock state is updated in the same
    // cycle, so the following request always sees the updated state.
    assign advance  = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;
    assign req_take = req.valid && req.ready;

    rwl_core #(
        .CPU_COUNT  (CPU_COUNT),
        .READER_MAX (READER_MAX)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .func     (func_reg),
        .cpu      (cpu_reg),
        .rd_count (rd_count),
        .wr_count (wr_count),
        .ctl      (cnt_ctl),
        .rsp      (rsp_calc)
    );

    // Per-CPU read and write acquisition counters.
    rwl_counters #(
        .CPU_COUNT (CPU_COUNT)
    ) u_counters (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .ctl      (cnt_ctl),
        .rd_count (rd_count),
        .wr_count (wr_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                req_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            func_reg <= req.func;
            cpu_reg  <= req.cpu;
        end
        if (advance)
        begin
            rsp_reg <= rsp_calc;
        end
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.granted           = rsp_reg.granted;
    assign rsp.fault             = rsp_reg.fault;
    assign rsp.readers_now       = rsp_reg.readers_now;
    assign rsp.writer_held       = rsp_reg.writer_held;
    assign rsp.writers_waiting   = rsp_reg.writers_waiting;
    assign rsp.read_grants_seen  = rsp_reg.read_grants_seen;
    assign rsp.write_grants_seen = rsp_reg.write_grants_seen;
endmodule

### test/reader_writer_lock_unit_tb.sv
`timescale 1ns / 100ps

module reader_writer_lock_unit_tb;
    import rwl_pkg::*;

    // Block configuration, mirrored in the lock model below.
    localparam int CPU_COUNT  = 8;
    localparam int READER_MAX = 255;
    localparam int READ_LIMIT = (READER_MAX < READERS_CAP) ? READER_MAX : READERS_CAP;
    localparam int WAIT_LIMIT = (CPU_COUNT < WAITING_CAP) ? CPU_COUNT : WAITING_CAP;

    // Stimulus volume and run guards.
    localparam int ITEM_TOTAL   = 1550;
    localparam int FILL_AT      = 700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD_AT = 400;

    // Lock model. It keeps its own copy of the lock state and of the per-CPU
    // grant counters, works out the response owed for every accepted request
    // and compares returned responses against the oldest one still owed.
    class rw_lock_mirror;
        logic [READERS_W-1:0] readers;
        logic                 writer_on;
        logic [CPU_W-1:0]     owner;
        logic [WAITING_W-1:0] waiting;
        logic [COUNT_W-1:0]   read_cnt [CPU_COUNT];
        logic [COUNT_W-1:0]   write_cnt [CPU_COUNT];
        rsp_t                 owed [$];
        int                   errors;

        function new();
            readers   = '0;
            writer_on = 1'b0;
            owner     = '0;
            waiting   = '0;
            errors    = 0;
            clear_counts();
        endfunction

        function void clear_counts();
            foreach (read_cnt[i])
            begin
                read_cnt[i]  = '0;
                write_cnt[i] = '0;
            end
        endfunction

        // A write grant needs the lock completely free.
        function bit take_write(logic [CPU_W-1:0] who);
            if (writer_on || readers != 0)
                return 1'b0;
            writer_on = 1'b1;
            owner     = who;
            if (int'(who) < CPU_COUNT)
                write_cnt[who] = write_cnt[who] + COUNT_W'(1);
            return 1'b1;
        endfunction

        function void apply_request(func_t op, logic [CPU_W-1:0] who);
            rsp_t r;
            r = '0;
            case (op)
                FN_TRY_READ:
                begin
                    // Writers waiting or holding block new readers.
                    if (!writer_on && waiting == 0 && readers < READ_LIMIT)
                    begin
                        readers = readers + READERS_W'(1);
                        if (int'(who) < CPU_COUNT)
                            read_cnt[who] = read_cnt[who] + COUNT_W'(1);
                        r.granted = 1'b1;
                    end
                end
                FN_TRY_WRITE:
                    r.granted = take_write(who);
                FN_ANNOUNCE:
                begin
                    if (waiting >= WAIT_LIMIT)
                        r.fault = 1'b1;
                    else
                        waiting = waiting + WAITING_W'(1);
                end
                FN_ANNOUNCED_TRY:
                begin
                    if (take_write(who))
                    begin
                        r.granted = 1'b1;
                        if (waiting != 0)
                            waiting = waiting - WAITING_W'(1);
                    end
                end
                FN_READ_UNLOCK:
                begin
                    if (readers == 0)
                        r.fault = 1'b1;
                    else
                        readers = readers - READERS_W'(1);
                end
                FN_WRITE_UNLOCK:
                begin
                    if (!writer_on || owner != who)
                        r.fault = 1'b1;
                    else
                    begin
                        writer_on = 1'b0;
                        owner     = '0;
                    end
                end
                FN_STATS_READ:
                begin
                    if (int'(who) < CPU_COUNT)
                    begin
                        r.read_grants_seen  = read_cnt[who];
                        r.write_grants_seen = write_cnt[who];
                    end
                end
                default:
                    clear_counts();
            endcase
            r.readers_now     = readers;
            r.writer_held     = writer_on;
            r.writers_waiting = waiting;
            owed.push_back(r);
        endfunction

        function void compare_field(string field, logic [COUNT_W-1:0] want_v,
                                    logic [COUNT_W-1:0] got_v);
            if (want_v !== got_v)
            begin
                $error("%s: expected %0d, got %0d", field, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (owed.size() == 0)
            begin
                $error("response returned with no request outstanding");
                errors++;
                return;
            end
            want = owed.pop_front();
            compare_field("granted", COUNT_W'(want.granted), COUNT_W'(got.granted));
            compare_field("fault", COUNT_W'(want.fault), COUNT_W'(got.fault));
            compare_field("readers_now", COUNT_W'(want.readers_now),
                          COUNT_W'(got.readers_now));
            compare_field("writer_held", COUNT_W'(want.writer_held),
                          COUNT_W'(got.writer_held));
            compare_field("writers_waiting", COUNT_W'(want.writers_waiting),
                          COUNT_W'(got.writers_waiting));
            compare_field("read_grants_seen", want.read_grants_seen, got.read_grants_seen);
            compare_field("write_grants_seen", want.write_grants_seen,
                          got.write_grants_seen);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rwl_req_if req_ch ();
    rwl_rsp_if rsp_ch ();

    reader_writer_lock_unit #(
        .CPU_COUNT  (CPU_COUNT),
        .READER_MAX (READER_MAX)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rw_lock_mirror lock_mirror;

    int sent_count    = 0;
    int rsp_count     = 0;
    int cycle_count   = 0;
    int sender_calm   = 0;
    int receiver_calm = 0;
    int receiver_hold = 0;
    bit long_hold_done = 1'b0;
    bit fill_done      = 1'b0;

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [CPU_W-1:0] any_cpu();
        return CPU_W'($urandom_range(0, CPU_CODES - 1));
    endfunction

    // Offers one request from the falling edge on, holds it until the block
    // takes it, feeds it to the lock model and then leaves a random gap. Most
    // gaps are zero so that requests stream back to back; runs of calm
    // streaming alternate with short and occasional long pauses.
    task automatic send_request(input func_t op, input logic [CPU_W-1:0] who);
        int gap;
        int pick;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.func  <= op;
        req_ch.cpu   <= who;
        do
            @(posedge clk);
        while (!req_ch.ready);
        lock_mirror.apply_request(op, who);
        sent_count++;
        gap = 0;
        if (sender_calm > 0)
            sender_calm--;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                sender_calm = $urandom_range(20, 100);
            else if (pick < 8)
                gap = $urandom_range(10, 30);
            else if (pick < 35)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Response receiver. Ready changes only at falling edges. Besides random
    // stalls it holds off once for a long stretch while the sender keeps
    // offering requests, so the block's pipeline fills and it stops taking
    // requests.
    initial
    begin
        int pick;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && rsp_count >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                receiver_hold  = 120;
            end
            if (receiver_hold > 0)
            begin
                receiver_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (receiver_calm > 0)
            begin
                receiver_calm--;
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    receiver_hold = $urandom_range(10, 40);
                    rsp_ch.ready <= 1'b0;
                end
                else if (pick < 8)
                begin
                    receiver_calm = $urandom_range(20, 80);
                    rsp_ch.ready <= 1'b1;
                end
                else if (pick < 30)
                    rsp_ch.ready <= 1'b0;
                else
                    rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Every accepted response is checked against the oldest owed one.
    always @(posedge clk)
    begin : rsp_monitor
        rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.granted           = rsp_ch.granted;
            got.fault             = rsp_ch.fault;
            got.readers_now       = rsp_ch.readers_now;
            got.writer_held       = rsp_ch.writer_held;
            got.writers_waiting   = rsp_ch.writers_waiting;
            got.read_grants_seen  = rsp_ch.read_grants_seen;
            got.write_grants_seen = rsp_ch.write_grants_seen;
            lock_mirror.check_response(got);
            rsp_count++;
        end
    end

    // Main sequence: reset, a directed walk through the lock rules, then
    // randomized rounds shaped like real lock traffic, then the drain.
    initial
    begin
        int               pick;
        int               sub;
        int               n;
        int               tries;
        logic [CPU_W-1:0] c;
        logic [CPU_W-1:0] d;

        lock_mirror  = new();
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func  = FN_TRY_READ;
        req_ch.cpu   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Counters start at zero, and both unlocks fault on an
        // idle lock without changing anything.
        send_request(FN_STATS_READ, 3'd0);
        send_request(FN_READ_UNLOCK, 3'd0);
        send_request(FN_WRITE_UNLOCK, 3'd0);
        // Two readers share the lock; a writer is refused while they hold it.
        send_request(FN_TRY_READ, 3'd0);
        send_request(FN_TRY_READ, 3'd7);
        send_request(FN_TRY_WRITE, 3'd3);
        send_request(FN_READ_UNLOCK, 3'd0);
        send_request(FN_READ_UNLOCK, 3'd7);
        // A writer on the highest CPU index; readers are refused and an unlock
        // by another CPU faults before the owner releases.
        send_request(FN_TRY_WRITE, 3'd7);
        send_request(FN_TRY_READ, 3'd1);
        send_request(FN_WRITE_UNLOCK, 3'd2);
        send_request(FN_WRITE_UNLOCK, 3'd7);
        // An announced try with nobody announced behaves as a plain write try.
        send_request(FN_ANNOUNCED_TRY, 3'd5);
        send_request(FN_WRITE_UNLOCK, 3'd5);
        // Fill the waiting-writer count to its limit, then overflow it.
        for (int i = 0; i < WAIT_LIMIT; i++)
            send_request(FN_ANNOUNCE, CPU_W'(i));
        send_request(FN_ANNOUNCE, 3'd1);
        // Waiting writers block readers; an announced try takes one off.
        send_request(FN_TRY_READ, 3'd2);
        send_request(FN_ANNOUNCED_TRY, 3'd4);
        send_request(FN_STATS_READ, 3'd7);
        send_request(FN_STATS_CLEAR, 3'd6);
        send_request(FN_STATS_READ, 3'd7);

        // Random rounds until the request budget is spent.
        while (sent_count < ITEM_TOTAL)
        begin
            if (!fill_done && sent_count >= FILL_AT)
            begin
                // Once per run the reader count is driven to its ceiling.
                // First the lock is freed of writers and waiting writers.
                fill_done = 1'b1;
                tries = 0;
                while ((lock_mirror.writer_on || lock_mirror.waiting != 0) && tries < 600)
                begin
                    if (lock_mirror.writer_on)
                        send_request(FN_WRITE_UNLOCK, lock_mirror.owner);
                    else if (lock_mirror.readers != 0)
                        send_request(FN_READ_UNLOCK, any_cpu());
                    else
                        send_request(FN_ANNOUNCED_TRY, any_cpu());
                    tries++;
                end
                while (lock_mirror.readers < READ_LIMIT)
                    send_request(FN_TRY_READ, any_cpu());
                // Reads at the ceiling are refused.
                repeat (3) send_request(FN_TRY_READ, any_cpu());
                send_request(FN_TRY_WRITE, any_cpu());
                send_request(FN_STATS_READ, any_cpu());
                send_request(FN_STATS_READ, any_cpu());
                // Drain to zero, then one unlock too many.
                while (lock_mirror.readers != 0)
                    send_request(FN_READ_UNLOCK, any_cpu());
                send_request(FN_READ_UNLOCK, any_cpu());
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                begin
                    // Noise: any operation from any CPU.
                    n = $urandom_range(1, 20);
                    repeat (n) send_request(func_t'($urandom_range(0, 7)), any_cpu());
                end
                else if (pick < 50)
                begin
                    // Reader traffic: acquisitions and releases from many CPUs.
                    n = $urandom_range(5, 30);
                    repeat (n)
                    begin
                        sub = $urandom_range(0, 99);
                        if (sub < 55)
                            send_request(FN_TRY_READ, any_cpu());
                        else if (sub < 85)
                            send_request(FN_READ_UNLOCK, any_cpu());
                        else
                            send_request(FN_STATS_READ, any_cpu());
                    end
                end
                else if (pick < 85)
                begin
                    // Writer protocol: announce, spin on announced tries while
                    // readers drain, work under the lock, then release.
                    c = any_cpu();
                    send_request(FN_ANNOUNCE, c);
                    tries = 0;
                    while (!(lock_mirror.writer_on && lock_mirror.owner == c) && tries < 40)
                    begin
                        if (lock_mirror.writer_on)
                        begin
                            if ($urandom_range(0, 3) == 0)
                                send_request(FN_WRITE_UNLOCK,
                                             lock_mirror.owner ^ CPU_W'($urandom_range(1, 7)));
                            else
                                send_request(FN_WRITE_UNLOCK, lock_mirror.owner);
                        end
                        else if (lock_mirror.readers != 0)
                        begin
                            sub = $urandom_range(0, 3);
                            if (sub < 2)
                                send_request(FN_READ_UNLOCK, any_cpu());
                            else if (sub == 2)
                                send_request(FN_TRY_READ, any_cpu());
                            else
                                send_request(FN_ANNOUNCED_TRY, c);
                        end
                        else
                            send_request(FN_ANNOUNCED_TRY, c);
                        tries++;
                    end
                    if (lock_mirror.writer_on && lock_mirror.owner == c)
                    begin
                        n = $urandom_range(0, 4);
                        repeat (n)
                        begin
                            sub = $urandom_range(0, 3);
                            if (sub == 0)
                                send_request(FN_TRY_READ, any_cpu());
                            else if (sub == 1)
                                send_request(FN_TRY_WRITE, any_cpu());
                            else if (sub == 2)
                                send_request(FN_STATS_READ, c);
                            else
                                send_request(FN_WRITE_UNLOCK, c ^ CPU_W'($urandom_range(1, 7)));
                        end
                        send_request(FN_WRITE_UNLOCK, c);
                    end
                    // Sometimes serve every writer still waiting.
                    if ($urandom_range(0, 1) == 1)
                    begin
                        tries = 0;
                        while (lock_mirror.waiting != 0 && tries < 20)
                        begin
                            d = any_cpu();
                            send_request(FN_ANNOUNCED_TRY, d);
                            if (lock_mirror.writer_on)
                                send_request(FN_WRITE_UNLOCK, lock_mirror.owner);
                            else if (lock_mirror.readers != 0)
                                send_request(FN_READ_UNLOCK, any_cpu());
                            tries++;
                        end
                    end
                end
                else if (pick < 95)
                begin
                    // Counter sweep over all CPUs, sometimes with a clear.
                    for (int i = 0; i < CPU_CODES; i++)
                        send_request(FN_STATS_READ, CPU_W'(i));
                    if ($urandom_range(0, 9) < 3)
                    begin
                        send_request(FN_STATS_CLEAR, any_cpu());
                        send_request(FN_STATS_READ, any_cpu());
                    end
                end
                else
                begin
                    // Burst of announcements that may overflow the count.
                    n = $urandom_range(6, 10);
                    repeat (n) send_request(FN_ANNOUNCE, any_cpu());
                end
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Wait for every owed response, then go on watching to catch any stray
        // response from the block.
        while (lock_mirror.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (lock_mirror.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
